[rtl/core/text_slot_cache_with_frame_aging_macros.svh]
// Assertion macros for the text slot cache checker
`ifndef TEXT_SLOT_CACHE_WITH_FRAME_AGING_MACROS_SVH
`define TEXT_SLOT_CACHE_WITH_FRAME_AGING_MACROS_SVH
// assert that a antecedent implies a consequent in the same cycle
`define TSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/tsc_pkg.sv]
// Shared types and constants of the text slot cache
`timescale 1ns / 1ps
package tsc_pkg;
    localparam int SLOTS = 32;
    localparam int IDX_W = 6;
    localparam int SIDX_W = $clog2(SLOTS);
    localparam int SCNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] K_INIT  = 3'd0;
    localparam logic [2:0] K_INS   = 3'd1;
    localparam logic [2:0] K_FIND  = 3'd2;
    localparam logic [2:0] K_DRAW  = 3'd3;
    localparam logic [2:0] K_FRAME = 3'd4;
    localparam logic [2:0] K_CLEAR = 3'd5;

    localparam logic [2:0] S_OK     = 3'd0;
    localparam logic [2:0] S_NOTFND = 3'd1;
    localparam logic [2:0] S_NOSPC  = 3'd2;
    localparam logic [2:0] S_NOTRDY = 3'd3;
    localparam logic [2:0] S_RENDER = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [1:0] ST_EMPTY    = 2'd0;
    localparam logic [1:0] ST_INSERT   = 2'd1;
    localparam logic [1:0] ST_RENDER   = 2'd2;
    localparam logic [1:0] ST_RERENDER = 2'd3;

    localparam logic [1:0] R_TEX_W  = 2'd0;
    localparam logic [1:0] R_TEX_H  = 2'd1;
    localparam logic [1:0] R_LINE_H = 2'd2;
    localparam logic [1:0] R_OUTL   = 2'd3;

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_DIV  = 7'b0000010,
        C_CLR  = 7'b0000100,
        C_SCAN = 7'b0001000,
        C_EMIT = 7'b0010000,
        C_FIN  = 7'b0100000,
        C_OUT  = 7'b1000000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // latch request, reset scan index
        logic       rewind;    // restart scan index for the free-slot pass
        logic       init_start;
        logic       div_step;
        logic       div_done;
        logic       clear_step;
        logic       scan_step; // examine slot at index, advance
        logic       set_result;
        logic [2:0] res_status;
        logic       res_has;
        logic       res_last;
        logic       res_from_scan; // scan result: insert or draw updates the slot at index
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic       scan_end;  // index reached the count of slots in use
        logic       hit;       // current slot matches lookup
        logic       hit_ins;   // current slot is inserted
        logic       empty_here;
        logic       div_end;
    } t_sts;

    function automatic logic [8:0] margin_of(input logic [1:0] mode);
        unique case (mode)
            2'd0: margin_of = 9'd0;
            2'd1: margin_of = 9'd1;
            2'd2: margin_of = 9'd4;
            default: margin_of = 9'd2;
        endcase
    endfunction
endpackage

[rtl/core/text_slot_cache_with_frame_aging.sv]
// Top level of the text slot cache with frame aging
// One request at a time: the input is ready only while the block is idle and no
// result waits. Find and draw scan the slots in use one per cycle. Insert scans once
// for its tag and, if the tag is absent, a second time for the first empty slot.
// Init divides the texture height by the row height (13 quotient steps and one to
// saturate), then clears the slots in use one per cycle, as clear all does. Frame
// end walks every slot in use and holds on each render result until it is taken.
// Configuration writes are always accepted and take effect at the next init.
`timescale 1ns / 1ps
module text_slot_cache_with_frame_aging (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // text_key
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // status[2:0], slot_index[8:3], slot_top[20:9],
                                       // slot_height[29:21], zero[31:30]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    tsc_pkg::t_cmd w_cmd;
    tsc_pkg::t_sts w_sts;
    logic [2:0]  w_status;
    logic [5:0]  w_idx;
    logic [11:0] w_top;
    logic [8:0]  w_h;

    assign o_cfg_ready = 1'b1;

    tsc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_last(m_axis_tlast), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    tsc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_kind(s_axis_tuser), .i_key(s_axis_tdata),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_status(w_status), .o_slot_index(w_idx), .o_slot_top(w_top),
        .o_slot_height(w_h)
    );

    assign m_axis_tdata = {2'b00, w_h, w_top, w_idx, w_status};
endmodule

[rtl/core/tsc_datapath.sv]
// Datapath: slot store, scan index, divider and result register
`timescale 1ns / 1ps
module tsc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsc_pkg::t_cmd     i_cmd,
    output tsc_pkg::t_sts     o_sts,
    input  logic [2:0]        i_kind,
    input  logic [31:0]       i_key,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [12:0]       i_cfg_data,
    output logic [2:0]        o_status,
    output logic [5:0]        o_slot_index,
    output logic [11:0]       o_slot_top,
    output logic [8:0]        o_slot_height
);
    logic [12:0] r_tex_h;
    logic [7:0]  r_line_h;
    logic [1:0]  r_outl;
    logic [31:0] r_tag [tsc_pkg::SLOTS];
    logic [1:0]  r_st [tsc_pkg::SLOTS];
    logic [tsc_pkg::SCNT_W-1:0] r_used;
    logic [8:0]  r_rowh;
    logic [2:0]  r_kind;
    logic [31:0] r_key;
    logic [tsc_pkg::SCNT_W-1:0] r_idx;
    logic [12:0] r_rem;
    logic [12:0] r_quo;
    logic [3:0]  r_dcnt;
    logic [13:0] w_trial;
    logic [12:0] n_quo;
    logic [12:0] n_rem;
    logic [tsc_pkg::SIDX_W-1:0] w_i;
    logic [1:0]  w_cur;
    logic        w_tag_eq;
    logic [20:0] w_top;
    logic [8:0]  w_newh;

    assign w_i = r_idx[tsc_pkg::SIDX_W-1:0];
    assign w_cur = r_st[w_i];
    assign w_tag_eq = (r_tag[w_i] == r_key);
    assign w_newh = {1'b0, r_line_h} + tsc_pkg::margin_of(r_outl);

    always_comb begin
        o_sts.kind = r_kind;
        o_sts.scan_end = (r_idx >= r_used);
        o_sts.hit_ins = (w_cur == tsc_pkg::ST_INSERT);
        o_sts.empty_here = (w_cur == tsc_pkg::ST_EMPTY);
        if (r_kind == tsc_pkg::K_FIND) begin
            o_sts.hit = w_tag_eq && (w_cur == tsc_pkg::ST_RENDER ||
                                     w_cur == tsc_pkg::ST_RERENDER);
        end else begin
            o_sts.hit = w_tag_eq && (w_cur != tsc_pkg::ST_EMPTY);
        end
        o_sts.div_end = (r_dcnt == 4'd0);
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[12]};
        n_quo = {r_quo[11:0], 1'b0};
        n_rem = w_trial[12:0];
        if (w_trial >= {5'd0, r_rowh}) begin
            n_rem = 13'(w_trial - {5'd0, r_rowh});
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_h <= 13'd256;
            r_line_h <= 8'd16;
            r_outl <= 2'd0;
            r_used <= '0;
            r_rowh <= '0;
            r_kind <= '0;
            r_idx <= '0;
            r_dcnt <= '0;
            for (int k = 0; k < tsc_pkg::SLOTS; k++) r_st[k] <= tsc_pkg::ST_EMPTY;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tsc_pkg::R_TEX_W:  ;
                    tsc_pkg::R_TEX_H:  r_tex_h <= i_cfg_data;
                    tsc_pkg::R_LINE_H: r_line_h <= i_cfg_data[7:0];
                    default:           r_outl <= i_cfg_data[1:0];
                endcase
            end
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_key <= i_key;
                r_idx <= '0;
            end
            if (i_cmd.rewind) begin
                r_idx <= '0;
            end
            if (i_cmd.init_start) begin
                r_rowh <= w_newh;
                r_rem <= '0;
                r_quo <= r_tex_h;
                r_dcnt <= 4'd13;
            end
            if (i_cmd.div_step) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dcnt <= 4'(r_dcnt - 4'd1);
            end
            if (i_cmd.div_done) begin
                if (r_rowh == 9'd0) r_used <= '0;
                else if (r_quo > 13'(tsc_pkg::SLOTS)) r_used <= tsc_pkg::SCNT_W'(tsc_pkg::SLOTS);
                else r_used <= r_quo[tsc_pkg::SCNT_W-1:0];
            end
            if (i_cmd.clear_step) begin
                r_st[w_i] <= tsc_pkg::ST_EMPTY;
                r_idx <= tsc_pkg::SCNT_W'(r_idx + 1'b1);
            end
            if (i_cmd.scan_step) begin
                unique case (r_kind)
                    tsc_pkg::K_FRAME: begin
                        unique case (w_cur)
                            tsc_pkg::ST_INSERT:   r_st[w_i] <= tsc_pkg::ST_RENDER;
                            tsc_pkg::ST_RERENDER: r_st[w_i] <= tsc_pkg::ST_RENDER;
                            tsc_pkg::ST_RENDER:   r_st[w_i] <= tsc_pkg::ST_EMPTY;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                r_idx <= tsc_pkg::SCNT_W'(r_idx + 1'b1);
            end
            if (i_cmd.set_result && i_cmd.res_from_scan) begin
                if (r_kind == tsc_pkg::K_INS && !o_sts.hit) begin
                    r_tag[w_i] <= r_key;
                    r_st[w_i] <= tsc_pkg::ST_INSERT;
                end else if (r_kind == tsc_pkg::K_DRAW && !o_sts.hit_ins) begin
                    r_st[w_i] <= tsc_pkg::ST_RERENDER;
                end
            end
        end
    end

    assign w_top = {16'd0, w_i} * {12'd0, r_rowh};

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_result) begin
            o_status <= i_cmd.res_status;
            o_slot_height <= r_rowh;
            if (i_cmd.res_has) begin
                o_slot_index <= 6'(w_i);
                o_slot_top <= w_top[11:0];
            end else begin
                o_slot_index <= '0;
                o_slot_top <= '0;
            end
        end
    end
endmodule

[rtl/core/tsc_ctrl.sv]
// Controller state machine of the text slot cache
`timescale 1ns / 1ps
module tsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_out_last,
    output tsc_pkg::t_cmd o_cmd,
    input  tsc_pkg::t_sts i_sts
);
    tsc_pkg::t_state r_state, n_state;
    logic r_valid, n_valid;
    logic r_last, n_last;
    logic r_after; // 1 = insert still owes its free-slot pass, 0 = none
    logic n_after;

    assign o_out_valid = r_valid;
    assign o_out_last = r_last;
    assign o_in_ready = (r_state == tsc_pkg::C_IDLE) && !r_valid;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_valid = r_valid && !i_out_ready;
        n_last = r_last;
        n_after = r_after;
        unique case (r_state)
            tsc_pkg::C_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = tsc_pkg::C_SCAN;
                end
            end
            tsc_pkg::C_SCAN: begin
                unique case (i_sts.kind)
                    tsc_pkg::K_INIT: begin
                        o_cmd.init_start = 1'b1;
                        n_state = tsc_pkg::C_DIV;
                    end
                    tsc_pkg::K_CLEAR: n_state = tsc_pkg::C_CLR;
                    tsc_pkg::K_FRAME: begin
                        if (i_sts.scan_end) begin
                            n_state = tsc_pkg::C_FIN;
                        end else if (i_sts.hit_ins) begin
                            o_cmd.set_result = 1'b1;
                            o_cmd.res_status = tsc_pkg::S_RENDER;
                            o_cmd.res_has = 1'b1;
                            o_cmd.scan_step = 1'b1;
                            n_valid = 1'b1;
                            n_last = 1'b0;
                            n_state = tsc_pkg::C_EMIT;
                        end else begin
                            o_cmd.scan_step = 1'b1;
                        end
                    end
                    tsc_pkg::K_INS, tsc_pkg::K_FIND, tsc_pkg::K_DRAW: begin
                        if (i_sts.scan_end) begin
                            if (i_sts.kind == tsc_pkg::K_INS) begin
                                o_cmd.load = 1'b0;
                                n_state = tsc_pkg::C_EMIT; // second pass for empty
                                n_after = 1'b1;
                            end else begin
                                o_cmd.set_result = 1'b1;
                                o_cmd.res_status = tsc_pkg::S_NOTFND;
                                n_valid = 1'b1;
                                n_last = 1'b1;
                                n_state = tsc_pkg::C_OUT;
                            end
                        end else if (i_sts.hit) begin
                            o_cmd.set_result = 1'b1;
                            o_cmd.res_from_scan = 1'b1;
                            o_cmd.res_has = 1'b1;
                            o_cmd.res_status = (i_sts.kind == tsc_pkg::K_DRAW &&
                                i_sts.hit_ins) ? tsc_pkg::S_NOTRDY : tsc_pkg::S_OK;
                            n_valid = 1'b1;
                            n_last = 1'b1;
                            n_state = tsc_pkg::C_OUT;
                        end else begin
                            o_cmd.scan_step = 1'b1;
                        end
                    end
                    default: n_state = tsc_pkg::C_IDLE;
                endcase
            end
            tsc_pkg::C_EMIT: begin
                // frame end: wait until render result is taken; insert: free-slot pass
                if (i_sts.kind == tsc_pkg::K_INS) begin
                    if (r_after) begin
                        o_cmd.rewind = 1'b1;
                        n_after = 1'b0;
                        n_state = tsc_pkg::C_CLR;
                    end
                end else if (!r_valid || i_out_ready) begin
                    n_state = tsc_pkg::C_SCAN;
                end
            end
            tsc_pkg::C_DIV: begin
                if (i_sts.div_end) begin
                    o_cmd.div_done = 1'b1;
                    n_state = tsc_pkg::C_CLR;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            tsc_pkg::C_CLR: begin
                if (i_sts.kind == tsc_pkg::K_INS) begin
                    // free-slot search from the first slot
                    if (i_sts.scan_end) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.res_status = tsc_pkg::S_NOSPC;
                        n_valid = 1'b1;
                        n_last = 1'b1;
                        n_state = tsc_pkg::C_OUT;
                    end else if (i_sts.empty_here) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.res_from_scan = 1'b1;
                        o_cmd.res_has = 1'b1;
                        o_cmd.res_status = tsc_pkg::S_OK;
                        n_valid = 1'b1;
                        n_last = 1'b1;
                        n_state = tsc_pkg::C_OUT;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end else if (i_sts.scan_end) begin
                    n_state = tsc_pkg::C_FIN;
                end else begin
                    o_cmd.clear_step = 1'b1;
                end
            end
            tsc_pkg::C_FIN: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = tsc_pkg::S_DONE;
                    n_valid = 1'b1;
                    n_last = 1'b1;
                    n_state = tsc_pkg::C_OUT;
                end
            end
            tsc_pkg::C_OUT: begin
                if (!r_valid || i_out_ready) n_state = tsc_pkg::C_IDLE;
            end
            default: n_state = tsc_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::C_IDLE;
            r_valid <= 1'b0;
            r_last <= 1'b0;
            r_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last <= n_last;
            r_after <= n_after;
        end
    end
endmodule

[rtl/core/tsc_checker.sv]
// Port-level checker of the text slot cache and its bind
`timescale 1ns / 1ps
`include "text_slot_cache_with_frame_aging_macros.svh"
module tsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic        w_render;
    logic        w_done;
    logic        w_done_ok;
    logic        w_stall;
    logic        w_vld;
    logic [31:0] w_data;

    assign w_render = m_axis_tvalid && (m_axis_tdata[2:0] == tsc_pkg::S_RENDER);
    assign w_done = m_axis_tvalid && (m_axis_tdata[2:0] == tsc_pkg::S_DONE);
    assign w_done_ok = m_axis_tlast && (m_axis_tdata[8:3] == 6'd0);
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_vld = m_axis_tvalid;
    assign w_data = m_axis_tdata;

    `TSC_ASSERT_IMPL(a_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "ready while busy")
    `TSC_ASSERT_IMPL(a_render_not_last, i_clk, i_rst_n, w_render, !m_axis_tlast, "render last")
    `TSC_ASSERT_IMPL(a_done_last, i_clk, i_rst_n, w_done, w_done_ok, "done malformed")
    `TSC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, w_vld && $stable(w_data), "result moved")
endmodule

bind text_slot_cache_with_frame_aging tsc_checker u_tsc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

[verif/tb.sv]
// Self-checking testbench for the text slot cache with frame aging
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  idx;
        logic [11:0] top;
        logic [8:0]  height;
        logic        last;
    } t_res;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] key;
        logic        chk;
        logic [2:0]  status;
    } t_row;

    localparam int WD_LIMIT = 20000;
    localparam int DRAIN = 200;
    localparam logic [2:0] K_UNK_A = 3'd6;
    localparam logic [2:0] K_UNK_B = 3'd7;
    localparam logic [2:0] S_ANY = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    text_slot_cache_with_frame_aging dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [12:0] tex_w, tex_h;
    logic [7:0]  line_h;
    logic [1:0]  outl;
    logic [31:0] tag_q [tsc_pkg::SLOTS];
    logic [1:0]  st_q [tsc_pkg::SLOTS];
    int          used_n;
    logic [8:0]  row_h;

    t_res        exp_q[$];
    logic [2:0]  want_status[$];
    int          errors = 0;
    int          idle_cyc = 0;
    logic [31:0] keys [8];
    logic        stall_pat;

    function automatic t_res mk(logic [2:0] s, int i, bit has, logic l);
        t_res r;
        int t;
        t = i * int'(row_h);
        r.status = s;
        r.idx = has ? 6'(i) : '0;
        r.top = has ? 12'(t) : '0;
        r.height = row_h;
        r.last = l;
        return r;
    endfunction

    function automatic void queue_res(t_res r);
        exp_q = {exp_q, r};
    endfunction

    function automatic int find_slot(logic [31:0] k, bit shown_only);
        for (int i = 0; i < used_n; i++)
            if (st_q[i] != tsc_pkg::ST_EMPTY &&
                !(shown_only && st_q[i] == tsc_pkg::ST_INSERT) && tag_q[i] == k)
                return i;
        return -1;
    endfunction

    task automatic predict_cache(logic [2:0] kind, logic [31:0] k);
        int s;
        int c;
        bit done;
        case (kind)
            tsc_pkg::K_INIT: begin
                row_h = 9'({1'b0, line_h} + tsc_pkg::margin_of(outl));
                c = (row_h == 9'd0) ? 0 : int'(tex_h / {4'd0, row_h});
                used_n = (c > tsc_pkg::SLOTS) ? tsc_pkg::SLOTS : c;
                for (int i = 0; i < tsc_pkg::SLOTS; i++) st_q[i] = tsc_pkg::ST_EMPTY;
                queue_res(mk(tsc_pkg::S_DONE, 0, 0, 1));
            end
            tsc_pkg::K_INS: begin
                s = find_slot(k, 0);
                done = 0;
                if (s >= 0) begin
                    queue_res(mk(tsc_pkg::S_OK, s, 1, 1));
                    done = 1;
                end
                for (int i = 0; i < used_n && !done; i++)
                    if (st_q[i] == tsc_pkg::ST_EMPTY) begin
                        tag_q[i] = k;
                        st_q[i] = tsc_pkg::ST_INSERT;
                        queue_res(mk(tsc_pkg::S_OK, i, 1, 1));
                        done = 1;
                    end
                if (!done) queue_res(mk(tsc_pkg::S_NOSPC, 0, 0, 1));
            end
            tsc_pkg::K_FIND: begin
                s = find_slot(k, 1);
                queue_res(s >= 0 ? mk(tsc_pkg::S_OK, s, 1, 1) : mk(tsc_pkg::S_NOTFND, 0, 0, 1));
            end
            tsc_pkg::K_DRAW: begin
                s = find_slot(k, 0);
                if (s < 0) queue_res(mk(tsc_pkg::S_NOTFND, 0, 0, 1));
                else if (st_q[s] == tsc_pkg::ST_INSERT) queue_res(mk(tsc_pkg::S_NOTRDY, s, 1, 1));
                else begin
                    st_q[s] = tsc_pkg::ST_RERENDER;
                    queue_res(mk(tsc_pkg::S_OK, s, 1, 1));
                end
            end
            tsc_pkg::K_FRAME: begin
                for (int i = 0; i < used_n; i++)
                    case (st_q[i])
                        tsc_pkg::ST_INSERT: begin
                            st_q[i] = tsc_pkg::ST_RENDER;
                            queue_res(mk(tsc_pkg::S_RENDER, i, 1, 0));
                        end
                        tsc_pkg::ST_RERENDER: st_q[i] = tsc_pkg::ST_RENDER;
                        tsc_pkg::ST_RENDER: st_q[i] = tsc_pkg::ST_EMPTY;
                        default: ;
                    endcase
                queue_res(mk(tsc_pkg::S_DONE, 0, 0, 1));
            end
            tsc_pkg::K_CLEAR: begin
                for (int i = 0; i < tsc_pkg::SLOTS; i++) st_q[i] = tsc_pkg::ST_EMPTY;
                queue_res(mk(tsc_pkg::S_DONE, 0, 0, 1));
            end
            default: ;
        endcase
    endtask

    // receiver: stall pattern and result check
    always @(posedge i_clk) begin
        t_res got, w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tdata[2:0];
                got.idx = m_axis_tdata[8:3];
                got.top = m_axis_tdata[20:9];
                got.height = m_axis_tdata[29:21];
                got.last = m_axis_tlast;
                if (exp_q.size() == 0) begin
                    $error("unexpected result %h", m_axis_tdata);
                    errors++;
                end else begin
                    w = exp_q.pop_front();
                    if (want_status.size() > 0 && w.last) begin
                        if (want_status[0] != S_ANY && want_status[0] != got.status) begin
                            $error("status table: exp %0d got %0d", want_status[0], got.status);
                            errors++;
                        end
                        void'(want_status.pop_front());
                    end
                    if (got.status != w.status) begin
                        $error("status: exp %0d got %0d", w.status, got.status); errors++;
                    end
                    if (got.idx != w.idx) begin
                        $error("slot_index: exp %0d got %0d", w.idx, got.idx); errors++;
                    end
                    if (got.top != w.top) begin
                        $error("slot_top: exp %0d got %0d", w.top, got.top); errors++;
                    end
                    if (got.height != w.height) begin
                        $error("slot_height: exp %0d got %0d", w.height, got.height); errors++;
                    end
                    if (got.last != w.last) begin
                        $error("last: exp %0d got %0d", w.last, got.last); errors++;
                    end
                    if (m_axis_tdata[31:30] != 2'b00) begin
                        $error("pad: exp 0 got %0d", m_axis_tdata[31:30]); errors++;
                    end
                end
            end
            m_axis_tready <= stall_pat ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WD_LIMIT) begin
                $display("** text_slot_cache_with_frame_aging: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_req(logic [2:0] kind, logic [31:0] k);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= k;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_cache(kind, k);
    endtask

    task automatic gap_idle();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            tsc_pkg::R_TEX_W:  tex_w = val;
            tsc_pkg::R_TEX_H:  tex_h = val;
            tsc_pkg::R_LINE_H: line_h = val[7:0];
            default:           outl = val[1:0];
        endcase
    endtask

    task automatic set_cfg(logic [12:0] w, logic [12:0] h, logic [7:0] lh, logic [1:0] o);
        write_reg(tsc_pkg::R_TEX_W, w);
        write_reg(tsc_pkg::R_TEX_H, h);
        write_reg(tsc_pkg::R_LINE_H, {5'd0, lh});
        write_reg(tsc_pkg::R_OUTL, {11'd0, o});
    endtask

    task automatic run_random(int n);
        int burst;
        logic [2:0] kind;
        int p;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                gap_idle();
                burst = $urandom_range(1, 8);
            end
            burst--;
            p = $urandom_range(0, 99);
            kind = (p < 35) ? tsc_pkg::K_INS : (p < 55) ? tsc_pkg::K_FIND :
                   (p < 75) ? tsc_pkg::K_DRAW : (p < 88) ? tsc_pkg::K_FRAME :
                   (p < 92) ? tsc_pkg::K_CLEAR : (p < 95) ? tsc_pkg::K_INIT :
                   ($urandom_range(0, 1) == 0) ? K_UNK_A : K_UNK_B;
            send_req(kind, ($urandom_range(0, 3) == 0) ? $urandom() : keys[$urandom_range(0, 7)]);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    t_row dir_tab[$];

    initial begin
        tex_w = 13'd256; tex_h = 13'd256; line_h = 8'd16; outl = 2'd0;
        used_n = 0; row_h = '0;
        for (int i = 0; i < tsc_pkg::SLOTS; i++) begin
            st_q[i] = tsc_pkg::ST_EMPTY;
            tag_q[i] = '0;
        end
        for (int i = 0; i < 8; i++) keys[i] = $urandom();
        keys[0] = 32'h0; keys[1] = 32'hFFFF_FFFF;
        stall_pat = 1'b0;
        dir_tab = '{
            '{tsc_pkg::K_INS,   32'h1234, 1, tsc_pkg::S_NOSPC},
            '{tsc_pkg::K_FIND,  32'h1234, 1, tsc_pkg::S_NOTFND},
            '{tsc_pkg::K_DRAW,  32'h1234, 1, tsc_pkg::S_NOTFND},
            '{K_UNK_A,          32'h0,    0, tsc_pkg::S_OK},
            '{K_UNK_B,          32'h0,    0, tsc_pkg::S_OK},
            '{tsc_pkg::K_INIT,  32'h0,    1, tsc_pkg::S_DONE},
            '{tsc_pkg::K_INS,   32'h0,    1, tsc_pkg::S_OK},
            '{tsc_pkg::K_INS,   32'hFFFF_FFFF, 1, tsc_pkg::S_OK},
            '{tsc_pkg::K_INS,   32'h0,    1, tsc_pkg::S_OK},
            '{tsc_pkg::K_FIND,  32'h0,    1, tsc_pkg::S_NOTFND},
            '{tsc_pkg::K_DRAW,  32'h0,    1, tsc_pkg::S_NOTRDY},
            '{tsc_pkg::K_FRAME, 32'h0,    0, tsc_pkg::S_OK},
            '{tsc_pkg::K_FIND,  32'hFFFF_FFFF, 1, tsc_pkg::S_OK},
            '{tsc_pkg::K_DRAW,  32'h0,    1, tsc_pkg::S_OK},
            '{tsc_pkg::K_FRAME, 32'h0,    0, tsc_pkg::S_OK},
            '{tsc_pkg::K_FIND,  32'hFFFF_FFFF, 1, tsc_pkg::S_NOTFND},
            '{tsc_pkg::K_FIND,  32'h0,    1, tsc_pkg::S_OK},
            '{tsc_pkg::K_CLEAR, 32'h0,    1, tsc_pkg::S_DONE},
            '{tsc_pkg::K_FIND,  32'h0,    1, tsc_pkg::S_NOTFND}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind <= tsc_pkg::K_CLEAR)
                want_status = {want_status, (dir_tab[i].chk ? dir_tab[i].status : S_ANY)};
            send_req(dir_tab[i].kind, dir_tab[i].key);
            if (i % 3 == 2) gap_idle();
        end
        wait_drained();
        // tall rows, then tiny rows that saturate the count
        set_cfg(13'd4096, 13'd4096, 8'd255, 2'd2);
        send_req(tsc_pkg::K_INIT, 0);
        run_random(15);
        wait_drained();
        set_cfg(13'd1, 13'd4096, 8'd1, 2'd0);
        send_req(tsc_pkg::K_INIT, 0);
        run_random(30);
        wait_drained();
        stall_pat = 1'b1;
        set_cfg(13'd1, 13'd1, 8'd0, 2'd0);
        send_req(tsc_pkg::K_INIT, 0);
        run_random(10);
        wait_drained();
        set_cfg(13'($urandom_range(1, 4096)), 13'd300, 8'd7, 2'd3);
        send_req(tsc_pkg::K_INIT, 0);
        run_random(20);
        wait_drained();
        stall_pat = 1'b0;
        set_cfg(13'd2000, 13'd4096, 8'd100, 2'd1);
        send_req(tsc_pkg::K_INIT, 0);
        run_random(20);
        wait_drained();
        if (errors == 0)
            $display("** text_slot_cache_with_frame_aging: PASSED **");
        else
            $display("** text_slot_cache_with_frame_aging: FAILED **");
        $finish;
    end
endmodule
